// ===== hdl/fixed_point_decimal_field_formatter_unit_defines.svh =====
// Assertion macros shared by the formatter RTL.
`ifndef FIXED_POINT_DECIMAL_FIELD_FORMATTER_UNIT_DEFINES_SVH
`define FIXED_POINT_DECIMAL_FIELD_FORMATTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPDF_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define FPDF_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define FPDF_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define FPDF_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// ===== hdl/fpdf_pkg.sv =====
// Types, constants and power-of-ten tables of the decimal field formatter.
package fpdf_pkg;
    localparam int WIDTH_MAX    = 16;
    localparam int FRACTION_MAX = 9;
    localparam int NDIGITS      = 20;
    localparam int SCALE_MAX    = 18;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_INVAL = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_FRAC   = 3'd1,
        CFG_ALIGN  = 3'd2,
        CFG_OFILL  = 3'd3,
        CFG_PAD    = 3'd4,
        CFG_OCODE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_MAG, S_CHK, S_DIV, S_MUL, S_BCD, S_PREP, S_ARM, S_EMIT, S_FILL, S_STAT
    } t_state;

    typedef enum logic [2:0] {
        SG_LPAD  = 3'd0,
        SG_SIGN  = 3'd1,
        SG_ZPAD  = 3'd2,
        SG_INT   = 3'd3,
        SG_POINT = 3'd4,
        SG_FRAC  = 3'd5,
        SG_TPAD  = 3'd6
    } t_seg;

    function automatic logic [63:0] pow10(input logic [4:0] k);
        case (k)
            5'd0:  pow10 = 64'd1;
            5'd1:  pow10 = 64'd10;
            5'd2:  pow10 = 64'd100;
            5'd3:  pow10 = 64'd1000;
            5'd4:  pow10 = 64'd10000;
            5'd5:  pow10 = 64'd100000;
            5'd6:  pow10 = 64'd1000000;
            5'd7:  pow10 = 64'd10000000;
            5'd8:  pow10 = 64'd100000000;
            5'd9:  pow10 = 64'd1000000000;
            5'd10: pow10 = 64'd10000000000;
            5'd11: pow10 = 64'd100000000000;
            5'd12: pow10 = 64'd1000000000000;
            5'd13: pow10 = 64'd10000000000000;
            5'd14: pow10 = 64'd100000000000000;
            5'd15: pow10 = 64'd1000000000000000;
            5'd16: pow10 = 64'd10000000000000000;
            5'd17: pow10 = 64'd100000000000000000;
            5'd18: pow10 = 64'd1000000000000000000;
            default: pow10 = 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] half10(input logic [4:0] k);
        half10 = pow10(k) >> 1;
    endfunction

    // Largest magnitude that can be scaled up by ten to the k.
    function automatic logic [63:0] lim10(input logic [3:0] k);
        case (k)
            4'd0: lim10 = 64'd9223372036854775808;
            4'd1: lim10 = 64'd922337203685477580;
            4'd2: lim10 = 64'd92233720368547758;
            4'd3: lim10 = 64'd9223372036854775;
            4'd4: lim10 = 64'd922337203685477;
            4'd5: lim10 = 64'd92233720368547;
            4'd6: lim10 = 64'd9223372036854;
            4'd7: lim10 = 64'd922337203685;
            4'd8: lim10 = 64'd92233720368;
            4'd9: lim10 = 64'd9223372036;
            default: lim10 = 64'd0;
        endcase
    endfunction
endpackage

// ===== hdl/fpdf_if.sv =====
// Request and result channel interfaces of the decimal field formatter.
interface fpdf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] number;
    logic [4:0]  source_scale;
    logic        opcode;
    modport source (output valid, number, source_scale, opcode, input ready);
    modport sink (input valid, number, source_scale, opcode, output ready);
endinterface

interface fpdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic [1:0] status;
    logic       last;
    modport source (output valid, out_char, char_valid, status, last, input ready);
    modport sink (input valid, out_char, char_valid, status, last, output ready);
endinterface

// ===== hdl/fixed_point_decimal_field_formatter_unit.sv =====
// Fixed-point to decimal text field formatter, top level.
//
// A request on i_req carries a signed 64-bit value and its decimal scale. The
// block rescales it to the configured fraction digits and sends the field on
// o_res one character per result, left to right, with last on the final one.
// Errors give a single status-only result with char_valid low; a field too
// wide with overflow fill set instead sends width fill characters, status range.
// A request passes setup in S_MAG and S_CHK, then restoring division when the
// scale is reduced or multiply-by-ten steps when it is enlarged, then binary to
// BCD conversion and S_PREP and S_ARM to lay out the field; characters then
// leave at one per cycle while the receiver does not stall.
// i_req.ready is high only while no request is in work; the next request is
// taken as soon as the last character sits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the sequencer and the output valid flag and loads the register
// defaults: width 8, no fraction, right aligned, space padding, '#' fill.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data.
`include "fixed_point_decimal_field_formatter_unit_defines.svh"
module fixed_point_decimal_field_formatter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    fpdf_in_if.sink    i_req,
    fpdf_out_if.source o_res
);
    import fpdf_pkg::*;

    logic [4:0] r_width;
    logic [3:0] r_fd;
    logic       r_align, r_ofill;
    logic [7:0] r_pad, r_ocode;

    t_state r_state, n_state;
    logic [63:0] r_raw;
    logic [4:0]  r_scale;
    logic        r_op;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_div, n_div;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_sign;
    logic [NDIGITS-1:0][3:0] r_bcd, n_bcd;
    logic        r_neg, n_neg;
    t_seg        r_seg, n_seg;
    logic [4:0]  r_scnt, n_scnt;
    logic [4:0]  r_lpad, n_lpad, r_zpad, n_zpad, r_tpad, n_tpad, r_idig, n_idig;
    logic [4:0]  r_left, n_left;
    logic [1:0]  r_stat, n_stat;

    logic       r_ovalid;
    logic [7:0] r_och, n_och;
    logic       r_ocv, n_ocv, r_olast, n_olast;
    logic [1:0] r_ost, n_ost;

    logic        accept, load;
    logic        bad_cfg, range_red, range_enl;
    logic [4:0]  eff_scale, d_red;
    logic [3:0]  d_enl;
    logic        reduce;
    logic [64:0] rsum, rem2, diff;
    logic [4:0]  ndig;
    logic [5:0]  visible;
    logic [4:0]  pad;
    logic [4:0]  lens [0:6];
    t_seg        first_seg, next_seg;
    logic [4:0]  dig_idx;
    logic [3:0]  digit;
    logic [NDIGITS-1:0][3:0] adj;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign load = (r_state == S_EMIT || r_state == S_FILL || r_state == S_STAT)
               && (!r_ovalid || o_res.ready);

    assign o_res.valid      = r_ovalid;
    assign o_res.out_char   = r_och;
    assign o_res.char_valid = r_ocv;
    assign o_res.status     = r_ost;
    assign o_res.last       = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 5'd8;
            r_fd    <= 4'd0;
            r_align <= 1'b0;
            r_ofill <= 1'b0;
            r_pad   <= 8'd32;
            r_ocode <= 8'd35;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH: r_width <= i_cfg_data[4:0];
                CFG_FRAC:  r_fd    <= i_cfg_data[3:0];
                CFG_ALIGN: r_align <= i_cfg_data[0];
                CFG_OFILL: r_ofill <= i_cfg_data[0];
                CFG_PAD:   r_pad   <= i_cfg_data;
                CFG_OCODE: r_ocode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign bad_cfg = (r_op && r_fd != 4'd0) || r_width == 5'd0
                  || r_width > 5'(WIDTH_MAX) || r_fd > 4'(FRACTION_MAX);
    assign eff_scale = r_op ? 5'd0 : r_scale;
    assign reduce    = eff_scale > {1'b0, r_fd};
    assign d_red     = eff_scale - {1'b0, r_fd};
    assign d_enl     = r_fd - eff_scale[3:0];
    assign rsum      = {1'b0, r_acc} + {1'b0, half10(d_red)};
    assign range_red = d_red > 5'(SCALE_MAX)
                    || (!r_sign && rsum[64:63] != 2'b00)
                    || (r_sign && rsum > {2'b01, 63'd0});
    assign range_enl = r_acc > lim10(d_enl);

    assign rem2 = {r_rem, r_acc[63]};
    assign diff = rem2 - {1'b0, r_div};

    always_comb begin
        for (int i = 0; i < NDIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_comb begin
        ndig = 5'd0;
        for (int i = 0; i < NDIGITS; i++) begin
            if (r_bcd[i] != 4'd0) ndig = 5'(i + 1);
        end
    end

    always_comb begin
        lens[SG_LPAD]  = r_lpad;
        lens[SG_SIGN]  = {4'd0, r_neg};
        lens[SG_ZPAD]  = r_zpad;
        lens[SG_INT]   = r_idig;
        lens[SG_POINT] = {4'd0, r_fd != 4'd0};
        lens[SG_FRAC]  = {1'b0, r_fd};
        lens[SG_TPAD]  = r_tpad;
        first_seg = SG_INT;
        next_seg  = SG_TPAD;
        for (int j = 6; j >= 0; j--) begin
            if (lens[j] != 5'd0) first_seg = t_seg'(3'(j));
            if (j > int'(r_seg) && lens[j] != 5'd0) next_seg = t_seg'(3'(j));
        end
    end

    always_comb begin
        if (r_seg == SG_INT) begin
            dig_idx = r_idig - 5'd1 - r_scnt + {1'b0, r_fd};
        end else begin
            dig_idx = {1'b0, r_fd} - 5'd1 - r_scnt;
        end
        digit = r_bcd[dig_idx];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_MAG;
            S_MAG:  n_state = bad_cfg ? S_STAT : S_CHK;
            S_CHK: begin
                if (reduce) begin
                    n_state = range_red ? S_STAT : S_DIV;
                end else if (range_enl) begin
                    n_state = S_STAT;
                end else begin
                    n_state = (d_enl == 4'd0) ? S_BCD : S_MUL;
                end
            end
            S_DIV:  if (r_cnt == 6'd0) n_state = S_BCD;
            S_MUL:  if (r_cnt == 6'd1) n_state = S_BCD;
            S_BCD:  if (r_cnt == 6'd0) n_state = S_PREP;
            S_PREP: begin
                if (visible > {1'b0, r_width}) begin
                    n_state = r_ofill ? S_FILL : S_STAT;
                end else begin
                    n_state = S_ARM;
                end
            end
            S_ARM:  n_state = S_EMIT;
            S_EMIT, S_FILL, S_STAT: if (load && (r_left == 5'd1 || r_state == S_STAT)) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_neg  = r_sign && ndig != 5'd0;
        n_idig = (ndig > {1'b0, r_fd}) ? ndig - {1'b0, r_fd} : 5'd1;
        visible = {1'b0, n_idig} + {2'b0, r_fd} + {5'd0, n_neg};
        pad     = r_width - visible[4:0];
    end

    always_comb begin
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_bcd  = r_bcd;
        n_seg  = r_seg;
        n_scnt = r_scnt;
        n_lpad = r_lpad;
        n_zpad = r_zpad;
        n_tpad = r_tpad;
        n_left = r_left;
        n_stat = r_stat;
        n_och   = r_och;
        n_ocv   = r_ocv;
        n_ost   = r_ost;
        n_olast = r_olast;
        case (r_state)
            S_MAG: begin
                n_acc  = r_raw[63] ? 64'd0 - r_raw : r_raw;
                n_stat = STAT_INVAL;
            end
            S_CHK: begin
                n_stat = STAT_RANGE;
                n_bcd  = '0;
                n_cnt  = 6'd63;
                n_rem  = '0;
                if (reduce) begin
                    n_acc = rsum[63:0];
                    n_div = pow10(d_red);
                end else if (d_enl != 4'd0) begin
                    n_cnt = {2'd0, d_enl};
                end
            end
            S_DIV: begin
                if (!diff[64]) begin
                    n_rem = diff[63:0];
                end else begin
                    n_rem = rem2[63:0];
                end
                n_acc = {r_acc[62:0], !diff[64]};
                n_cnt = (r_cnt == 6'd0) ? 6'd63 : r_cnt - 6'd1;
            end
            S_MUL: begin
                n_acc = {r_acc[60:0], 3'd0} + {r_acc[62:0], 1'b0};
                n_cnt = (r_cnt == 6'd1) ? 6'd63 : r_cnt - 6'd1;
            end
            S_BCD: begin
                n_bcd = {adj[NDIGITS-1][2:0], adj[NDIGITS-2:0], r_acc[63]};
                n_acc = {r_acc[62:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
            end
            S_PREP: begin
                n_lpad = (!r_align && !(r_pad == CH_ZERO && n_neg)) ? pad : 5'd0;
                n_zpad = (!r_align && r_pad == CH_ZERO && n_neg) ? pad : 5'd0;
                n_tpad = r_align ? pad : 5'd0;
                n_left = (visible > {1'b0, r_width}) ? r_width
                       : r_width + {4'd0, r_fd != 4'd0};
            end
            S_ARM: begin
                n_seg  = first_seg;
                n_scnt = 5'd0;
            end
            S_EMIT: if (load) begin
                case (r_seg)
                    SG_SIGN:  n_och = CH_MINUS;
                    SG_POINT: n_och = CH_POINT;
                    SG_INT, SG_FRAC: n_och = CH_ZERO + {4'd0, digit};
                    default:  n_och = r_pad;
                endcase
                n_ocv   = 1'b1;
                n_ost   = STAT_OK;
                n_olast = (r_left == 5'd1);
                n_left  = r_left - 5'd1;
                if (r_scnt + 5'd1 < lens[r_seg]) begin
                    n_scnt = r_scnt + 5'd1;
                end else begin
                    n_scnt = 5'd0;
                    n_seg  = next_seg;
                end
            end
            S_FILL: if (load) begin
                n_och   = r_ocode;
                n_ocv   = 1'b1;
                n_ost   = STAT_RANGE;
                n_olast = (r_left == 5'd1);
                n_left  = r_left - 5'd1;
            end
            S_STAT: if (load) begin
                n_och   = 8'd0;
                n_ocv   = 1'b0;
                n_ost   = r_stat;
                n_olast = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw   <= i_req.number;
            r_scale <= i_req.source_scale;
            r_op    <= i_req.opcode;
            r_sign  <= i_req.number[63];
        end
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_cnt   <= n_cnt;
        r_bcd   <= n_bcd;
        r_neg   <= (r_state == S_PREP) ? n_neg : r_neg;
        r_idig  <= (r_state == S_PREP) ? n_idig : r_idig;
        r_seg   <= n_seg;
        r_scnt  <= n_scnt;
        r_lpad  <= n_lpad;
        r_zpad  <= n_zpad;
        r_tpad  <= n_tpad;
        r_left  <= n_left;
        r_stat  <= n_stat;
        r_och   <= n_och;
        r_ocv   <= n_ocv;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    `FPDF_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == S_MAG, "accept did not start work")
    `FPDF_ASSERT_NXT(a_last_idles, i_clk, i_rst_n, load && n_olast, r_state == S_IDLE, "last char did not end run")
    `FPDF_ASSERT_IMP(a_emit_left, i_clk, i_rst_n, r_state == S_EMIT || r_state == S_FILL, r_left != 5'd0, "no chars left")
    `FPDF_ASSERT_IMP(a_status_only, i_clk, i_rst_n, o_res.valid && !o_res.char_valid, o_res.last && o_res.status != STAT_OK, "bad status result")
endmodule
